@@ rtl/pncm_pkg.sv @@
// ----------------------------------------------------------------------------
// pncm_pkg: shared types and codes for the palette nearest color mapper
// Action codes, control state encoding and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pncm_pkg;

    localparam int COLOR_W   = 8;
    localparam int ENTRY_W   = 3 * COLOR_W;  // packed r, g, b
    localparam int INDEX_W   = 4;            // width of the entry_index field
    localparam int LIMIT_W   = 5;            // width of the palette_limit register
    localparam int SQ_W      = 2 * COLOR_W;  // square of one channel difference
    localparam int DIST_W    = SQ_W + 2;     // sum of three squares

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef logic [1:0] t_action;

    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_APPEND = 2'd1;
    localparam t_action ACT_MAP    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/pncm_ram.sv @@
// ----------------------------------------------------------------------------
// pncm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pncm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/palette_nearest_color_mapper.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_color_mapper: nearest palette color quantizer
// Keeps up to PALETTE_DEPTH RGB entries in a RAM and maps pixels to the
// entry with the smallest squared RGB distance (lowest index wins ties).
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  input     i_valid / o_ready    i_action i_in_r i_in_g i_in_b i_in_alpha
//                                 i_has_alpha i_last_pixel
//  output    o_valid / i_ready    o_out_r o_out_g o_out_b o_out_alpha
//                                 o_entry_index o_palette_used o_last_out
//  config    i_cfg_we (no wait)   i_cfg_wdata (palette_limit)
//
//  Clear and append words finish in the accept cycle. A map word against N
//  stored entries goes through the accept cycle, one RAM read per entry (the
//  single read port sets the pace), the draining of the two distance stages,
//  a check that sees the pipe empty and the hand-off of the result to the
//  output register. An empty palette goes from accept straight to hand-off.
//  Synchronous active-low reset clears the entry count and sets the limit
//  to 16; palette contents are not reset, only entries below the count are
//  ever read. The output register holds a finished word while the next
//  word is accepted; a stalled output only holds the block in the hand-off
//  cycle of the following map word.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_nearest_color_mapper #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_we,
    input  wire logic [4:0]              i_cfg_wdata,

    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire pncm_pkg::t_action       i_action,
    input  wire logic [7:0]              i_in_r,
    input  wire logic [7:0]              i_in_g,
    input  wire logic [7:0]              i_in_b,
    input  wire logic [7:0]              i_in_alpha,
    input  wire logic                    i_has_alpha,
    input  wire logic                    i_last_pixel,

    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [7:0]                   o_out_r,
    output logic [7:0]                   o_out_g,
    output logic [7:0]                   o_out_b,
    output logic [7:0]                   o_out_alpha,
    output logic [3:0]                   o_entry_index,
    output logic                         o_palette_used,
    output logic                         o_last_out
);

    import pncm_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // control
    t_state              r_state, n_state;
    logic [LIMIT_W-1:0]  r_limit;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_rd_idx;
    logic                r_v1, r_v2, r_first;
    logic                r_out_valid;

    // handshake decode
    logic                in_acc;
    logic                do_append;
    logic                append_ok;
    logic                rd_en;
    logic                out_load;

    // latched pixel
    logic [COLOR_W-1:0]  r_px_r, r_px_g, r_px_b, r_px_a;
    logic                r_px_last;

    // search pipeline
    logic [ENTRY_W-1:0]  rd_data;
    logic [AW-1:0]       r_idx1, r_idx2;
    logic [SQ_W-1:0]     r_sq_r, r_sq_g, r_sq_b;
    logic [ENTRY_W-1:0]  r_ent2;
    logic [DIST_W-1:0]   sum_sq;
    logic [COLOR_W-1:0]  ad_r, ad_g, ad_b;
    logic [COLOR_W-1:0]  e_r, e_g, e_b;

    // running best
    logic [DIST_W-1:0]   r_best_d;
    logic [AW-1:0]       r_best_idx;
    logic [ENTRY_W-1:0]  r_best_c;
    logic                r_best_used;

    // output register
    logic [COLOR_W-1:0]  r_o_r, r_o_g, r_o_b, r_o_a;
    logic [3:0]          r_o_idx;
    logic                r_o_used, r_o_last;

    assign in_acc    = i_valid && o_ready;
    assign append_ok = (LW'(r_count) < LW'(r_limit))
                    && (r_count < CW'(PALETTE_DEPTH));
    assign do_append = in_acc && (i_action == ACT_APPEND) && append_ok;
    assign rd_en     = (r_state == ST_SEARCH) && (r_rd_idx < r_count);

    // ---- palette store ------------------------------------------------------
    pncm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_r, i_in_g, i_in_b}),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // ---- control FSM --------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_action == ACT_MAP)) begin
                    n_state = (r_count == '0) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // all reads issued and both distance stages drained
                if (!rd_en && !r_v1 && !r_v2) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- config, count, read pointer, pipeline valids -----------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_acc && (i_action == ACT_CLEAR)) begin
                r_count <= '0;
            end else if (do_append) begin
                r_count <= r_count + 1'b1;
            end
            if (in_acc) begin
                r_rd_idx <= '0;
                r_first  <= 1'b1;
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_first <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- stage 1: absolute differences and squares --------------------------
    always_comb begin
        e_r  = rd_data[ENTRY_W-1 -: COLOR_W];
        e_g  = rd_data[SQ_W-1 -: COLOR_W];
        e_b  = rd_data[COLOR_W-1:0];
        ad_r = (r_px_r >= e_r) ? (r_px_r - e_r) : (e_r - r_px_r);
        ad_g = (r_px_g >= e_g) ? (r_px_g - e_g) : (e_g - r_px_g);
        ad_b = (r_px_b >= e_b) ? (r_px_b - e_b) : (e_b - r_px_b);
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_rd_idx[AW-1:0];
        if (r_v1) begin
            r_sq_r <= SQ_W'(ad_r) * SQ_W'(ad_r);
            r_sq_g <= SQ_W'(ad_g) * SQ_W'(ad_g);
            r_sq_b <= SQ_W'(ad_b) * SQ_W'(ad_b);
            r_ent2 <= rd_data;
            r_idx2 <= r_idx1;
        end
    end

    // ---- stage 2: sum and compare against the running best ------------------
    assign sum_sq = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            // latch pixel; empty palette passes the color straight through
            r_px_r      <= i_in_r;
            r_px_g      <= i_in_g;
            r_px_b      <= i_in_b;
            r_px_a      <= i_has_alpha ? i_in_alpha : '0;
            r_px_last   <= i_last_pixel;
            r_best_c    <= {i_in_r, i_in_g, i_in_b};
            r_best_idx  <= '0;
            r_best_used <= 1'b0;
        end else if (r_v2 && (r_first || (sum_sq < r_best_d))) begin
            // strict less-than keeps the lowest index on ties
            r_best_d    <= sum_sq;
            r_best_idx  <= r_idx2;
            r_best_c    <= r_ent2;
            r_best_used <= 1'b1;
        end
    end

    // ---- output register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_r    <= r_best_c[ENTRY_W-1 -: COLOR_W];
            r_o_g    <= r_best_c[SQ_W-1 -: COLOR_W];
            r_o_b    <= r_best_c[COLOR_W-1:0];
            r_o_a    <= r_px_a;
            r_o_idx  <= INDEX_W'(r_best_idx);
            r_o_used <= r_best_used;
            r_o_last <= r_px_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_r        = r_o_r;
    assign o_out_g        = r_o_g;
    assign o_out_b        = r_o_b;
    assign o_out_alpha    = r_o_a;
    assign o_entry_index  = r_o_idx;
    assign o_palette_used = r_o_used;
    assign o_last_out     = r_o_last;

    // ---- assertions ---------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PALETTE_DEPTH))
        else $error("entry count beyond palette depth");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!r_v1 && !r_v2))
        else $error("search pipeline busy while accepting a word");

    a_empty_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_MAP) && (r_count == '0))
            |=> (r_state == ST_FINISH) && !r_best_used)
        else $error("empty palette map did not go straight to hand-off");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("result load lost");

endmodule

`default_nettype wire
